[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Both expect i_clk and i_rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHECK_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every rising edge outside reset.
`define CHECK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

[hw/rtl/owus_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package owus_pkg;

    // Transaction sizes in bytes, kept within 1..8.
    localparam int READ_BYTES  = 8;
    localparam int WRITE_BYTES = 3;

    localparam int READ_BYTES_C  = (READ_BYTES < 1) ? 1 : ((READ_BYTES > 8) ? 8 : READ_BYTES);
    localparam int WRITE_BYTES_C = (WRITE_BYTES < 1) ? 1 :
                                   ((WRITE_BYTES > 8) ? 8 : WRITE_BYTES);

    localparam logic [6:0] READ_LEN   = 7'(8 * READ_BYTES_C);
    localparam logic [6:0] WRITE_LEN  = 7'(8 * WRITE_BYTES_C);
    localparam logic [6:0] SERIAL_LEN = 7'd64;
    localparam logic [6:0] BYTE_LEN   = 7'd8;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_ECHO  = 2'd2;

    // Result action.
    localparam logic ACT_SLOT = 1'b0;
    localparam logic ACT_DONE = 1'b1;

    // Result status.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_LINE_LOW    = 2'd1;
    localparam logic [1:0] ST_NO_PRESENCE = 2'd2;

    // UART bytes that form bus slots.
    localparam logic [7:0] RESET_SLOT = 8'hF0;
    localparam logic [7:0] ONE_SLOT   = 8'hFF;
    localparam logic [7:0] ZERO_SLOT  = 8'h00;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_RESET  = 4'd1;
    localparam logic [3:0] PH_ROM    = 4'd2;
    localparam logic [3:0] PH_SERIAL = 4'd3;
    localparam logic [3:0] PH_FUNC   = 4'd4;
    localparam logic [3:0] PH_WRITE  = 4'd5;
    localparam logic [3:0] PH_READ   = 4'd6;
    localparam logic [3:0] PH_BUSY   = 4'd7;

    // 1-Wire command codes.
    localparam logic [7:0] CMD_READ_ROM     = 8'h33;
    localparam logic [7:0] CMD_MATCH_ROM    = 8'h55;
    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] CMD_ALARM_SEARCH = 8'hEC;
    localparam logic [7:0] CMD_WRITE_PAD    = 8'h4E;
    localparam logic [7:0] CMD_READ_PAD     = 8'hBE;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        line_high;
        logic [7:0]  rom_command;
        logic [63:0] serial_number;
        logic [7:0]  function_command;
        logic [23:0] write_data;
        logic [7:0]  echo_byte;
    } t_in_item;

    typedef struct packed {
        logic        action;
        logic [7:0]  slot_byte;
        logic        reset_baud;
        logic [1:0]  status;
        logic [63:0] read_data;
        logic        busy_res;
    } t_out_item;

endpackage

`default_nettype wire

[hw/rtl/owus_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds one transaction until the engine takes it.
module owus_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  owus_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output owus_pkg::t_in_item o_item
);
    import owus_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hw/rtl/owus_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Slot sequencer state and the next-state/result logic for one transaction.
module owus_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  owus_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output owus_pkg::t_out_item o_res
);
    import owus_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [6:0]  r_cnt, n_cnt;
    logic [6:0]  cnt_inc;
    logic [7:0]  r_rom, n_rom;
    logic [7:0]  r_func, n_func;
    logic [63:0] r_serial, n_serial;
    logic [23:0] r_wdata, n_wdata;
    logic [63:0] r_shift, n_shift;
    logic        polling;

    function automatic logic [6:0] f_seg_len(input logic [3:0] ph);
        case (ph)
            PH_SERIAL: return SERIAL_LEN;
            PH_WRITE:  return WRITE_LEN;
            PH_READ:   return READ_LEN;
            default:   return BYTE_LEN;
        endcase
    endfunction

    function automatic logic [3:0] f_next_phase(input logic [3:0] ph,
                                                input logic [7:0] rom,
                                                input logic [7:0] func);
        logic [3:0] nxt;
        nxt = PH_IDLE;
        if (ph == PH_ROM) begin
            case (rom) inside
                CMD_READ_ROM, CMD_ALARM_SEARCH: nxt = PH_READ;
                CMD_MATCH_ROM:                  nxt = PH_SERIAL;
                CMD_SKIP_ROM:                   nxt = PH_FUNC;
                default:                        nxt = PH_IDLE;
            endcase
        end else if (ph == PH_SERIAL) begin
            nxt = PH_FUNC;
        end else if (ph == PH_FUNC) begin
            case (func)
                CMD_WRITE_PAD: nxt = PH_WRITE;
                CMD_READ_PAD:  nxt = PH_READ;
                default:       nxt = PH_IDLE;
            endcase
        end
        return nxt;
    endfunction

    // Byte for the slot that carries bit cnt of the given phase.
    function automatic logic [7:0] f_slot_byte(input logic [3:0]  ph,
                                               input logic [6:0]  cnt,
                                               input logic [7:0]  rom,
                                               input logic [63:0] serial,
                                               input logic [7:0]  func,
                                               input logic [23:0] wdata);
        logic [5:0] c;
        logic       b;
        c = cnt[5:0];
        case (ph)
            PH_ROM:    b = rom[c[2:0]];
            PH_SERIAL: b = serial[c];
            PH_FUNC:   b = func[c[2:0]];
            PH_WRITE:  b = (c < 6'd24) ? wdata[c[4:0]] : 1'b0;
            default:   b = 1'b1;
        endcase
        return b ? ONE_SLOT : ZERO_SLOT;
    endfunction

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_rom       = r_rom;
        n_func      = r_func;
        n_serial    = r_serial;
        n_wdata     = r_wdata;
        n_shift     = r_shift;
        cnt_inc     = r_cnt + 7'd1;
        polling     = (r_phase == PH_BUSY);
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (i_item.opcode)
            OP_START: begin
                n_rom       = i_item.rom_command;
                n_serial    = i_item.serial_number;
                n_func      = i_item.function_command;
                n_wdata     = i_item.write_data;
                n_shift     = '0;
                n_cnt       = '0;
                o_res_valid = 1'b1;
                if (!i_item.line_high) begin
                    n_phase      = PH_IDLE;
                    o_res.action = ACT_DONE;
                    o_res.status = ST_LINE_LOW;
                end else begin
                    n_phase          = PH_RESET;
                    o_res.action     = ACT_SLOT;
                    o_res.slot_byte  = RESET_SLOT;
                    o_res.reset_baud = 1'b1;
                end
            end
            OP_POLL: begin
                n_shift         = '0;
                n_cnt           = '0;
                n_phase         = PH_BUSY;
                o_res_valid     = 1'b1;
                o_res.action    = ACT_SLOT;
                o_res.slot_byte = ONE_SLOT;
            end
            OP_ECHO: begin
                if (r_phase == PH_RESET) begin
                    o_res_valid = 1'b1;
                    if (i_item.echo_byte == RESET_SLOT || i_item.echo_byte == ZERO_SLOT) begin
                        n_phase         = PH_IDLE;
                        o_res.action    = ACT_DONE;
                        o_res.status    = ST_NO_PRESENCE;
                        o_res.read_data = r_shift;
                    end else begin
                        n_phase         = PH_ROM;
                        n_cnt           = '0;
                        o_res.action    = ACT_SLOT;
                        o_res.slot_byte = f_slot_byte(PH_ROM, 7'd0, r_rom, r_serial,
                                                      r_func, r_wdata);
                    end
                end else if (r_phase != PH_IDLE) begin
                    if ((r_phase == PH_READ || r_phase == PH_BUSY) &&
                        i_item.echo_byte == ONE_SLOT && !r_cnt[6]) begin
                        n_shift[r_cnt[5:0]] = 1'b1;
                    end
                    if (cnt_inc >= f_seg_len(r_phase)) begin
                        n_phase = f_next_phase(r_phase, r_rom, r_func);
                        n_cnt   = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                    o_res_valid = 1'b1;
                    if (n_phase == PH_IDLE) begin
                        o_res.action    = ACT_DONE;
                        o_res.status    = ST_OK;
                        o_res.read_data = n_shift;
                        o_res.busy_res  = polling && (n_shift == '0);
                    end else begin
                        o_res.action    = ACT_SLOT;
                        o_res.slot_byte = f_slot_byte(n_phase, n_cnt, r_rom, r_serial,
                                                      r_func, r_wdata);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_rom    <= n_rom;
            r_func   <= n_func;
            r_serial <= n_serial;
            r_wdata  <= n_wdata;
            r_shift  <= n_shift;
        end
    end

    `CHECK_IMPLIES(a_idle_cnt_clear, r_phase == PH_IDLE, r_cnt == 7'd0,
                   "slot count not clear in idle")
    `CHECK_ALWAYS(a_cnt_in_segment, r_cnt < SERIAL_LEN,
                  "slot count ran past its segment")

endmodule

`default_nettype wire

[hw/rtl/one_wire_uart_slot_sequencer.sv]
// Path: the input register holds the accepted transaction, and its result is then
//   held in the result register for o_out_item.
// Throughput: one transaction per cycle while the result channel is not stalled;
//   the engine settles each step combinationally between the two registers.
// A stray echo or an unused opcode yields no result; the result register stays empty.
// Reset (i_rst_n low, synchronous): phase to idle, slot count and both valids cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module one_wire_uart_slot_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  owus_pkg::t_in_item  i_in_item,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output owus_pkg::t_out_item o_out_item
);
    import owus_pkg::*;

    logic      in_valid;
    t_in_item  in_item;
    logic      take;
    logic      res_valid;
    t_out_item res;

    logic      r_out_valid;
    t_out_item r_out_item;

    // Input register; stalls upstream only while its transaction waits.
    owus_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // The held transaction moves on when the result register is empty or
    // being emptied this cycle; the state update happens at the same edge.
    assign take = in_valid && (!r_out_valid || !i_out_stall);

    owus_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register. Transactions with no result leave it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `CHECK_IMPLIES(a_stall_from_output, o_in_stall, o_out_valid && i_out_stall,
                   "input stalled without output backpressure")
    `CHECK_IMPLIES(a_reset_baud_slot, o_out_valid && o_out_item.reset_baud,
                   (o_out_item.slot_byte == RESET_SLOT) && (o_out_item.action == ACT_SLOT),
                   "reset baud on a non-reset slot")
    `CHECK_IMPLIES(a_finish_clean, o_out_valid && (o_out_item.action == ACT_DONE),
                   (o_out_item.slot_byte == ZERO_SLOT) && !o_out_item.reset_baud,
                   "finish result carries slot fields")

endmodule

`default_nettype wire
